### rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// shared types and constants of the insertion sorter
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int DATA_WIDTH       = 32;
   localparam int CAPACITY_DEFAULT = 32;

   typedef enum logic [0:0] {
      ST_FILL,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic ins;
      logic shift;
   } cell_ctrl_type;

endpackage

### rtl/insertion_sorter_core.sv
// ----------------------------------------------------------------------------
// insertion_sorter_core
// stable streaming insertion sorter built as a chain of compare cells
// ----------------------------------------------------------------------------
// usage:
//   req_ beats carry a signed value and a last_in flag. on each accepted beat
//   every cell compares against the new value at once and larger entries
//   move up one cell, equal ones stay below it.
//   up to CAPACITY values are held; further beats of the set are dropped and
//   the overflow flag is raised on every rsp_ beat of that set.
//   a beat with last_in set is inserted, then the list drains from cell 0
//   in ascending order, one rsp_ beat per cycle the receiver takes, the
//   largest one marked last_out. the first rsp_ beat is offered the cycle
//   after the last req_ beat is accepted.
//   throughput: one req_ beat per cycle while filling; a set of n stored
//   values then drains by the one-entry-per-cycle shift down the cell chain,
//   paused while rsp_stall is high, and req_stall is high throughout.
//   rsp_stall simply holds the chain and the offered beat in place.
//   reset empties the chain and clears the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module insertion_sorter_core #(
   parameter int CAPACITY = isort_pkg::CAPACITY_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [isort_pkg::DATA_WIDTH-1:0] req_value,
   input  logic                                    req_last_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [isort_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                                    rsp_last_out,
   output logic                                    rsp_overflow
);

   isort_pkg::state_type     state_ff;
   isort_pkg::state_type     state_in;
   logic                     dropped_ff;
   logic                     dropped_in;
   isort_pkg::cell_ctrl_type ctrl;
   logic                     req_fire;
   logic                     rsp_fire;
   logic                     full;

   logic signed [isort_pkg::DATA_WIDTH-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]                     cell_valid;
   logic [CAPACITY-1:0]                     cell_gt;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [isort_pkg::DATA_WIDTH-1:0] left_value;
         logic                                    left_valid;
         logic                                    left_gt;
         logic signed [isort_pkg::DATA_WIDTH-1:0] right_value;
         logic                                    right_valid;

         if (g == 0) begin : g_first
            assign left_value = '0;
            assign left_valid = 1'b1;
            assign left_gt    = 1'b0;
         end else begin : g_inner
            assign left_value = cell_value[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_gt    = cell_gt[g-1];
         end

         if (g == CAPACITY - 1) begin : g_top
            assign right_value = '0;
            assign right_valid = 1'b0;
         end else begin : g_below
            assign right_value = cell_value[g+1];
            assign right_valid = cell_valid[g+1];
         end

         isort_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .ins_value   (req_value),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .left_gt     (left_gt),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[g]),
            .valid       (cell_valid[g]),
            .gt          (cell_gt[g])
         );
      end
   endgenerate

   assign full      = cell_valid[CAPACITY-1];
   assign req_stall = (state_ff == isort_pkg::ST_DRAIN);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == isort_pkg::ST_DRAIN);
   assign rsp_fire  = rsp_valid && !rsp_stall;

   assign rsp_sorted_value = cell_value[0];
   assign rsp_last_out     = !cell_valid[1];
   assign rsp_overflow     = dropped_ff;

   assign ctrl.ins   = req_fire && !full;
   assign ctrl.shift = rsp_fire;

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         isort_pkg::ST_FILL: begin
            if (req_fire && full) begin
               dropped_in = 1'b1;
            end
            if (req_fire && req_last_in) begin
               state_in = isort_pkg::ST_DRAIN;
            end
         end
         isort_pkg::ST_DRAIN: begin
            if (rsp_fire && rsp_last_out) begin
               state_in   = isort_pkg::ST_FILL;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = isort_pkg::ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= isort_pkg::ST_FILL;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   // assertions
   a_drain_has_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == isort_pkg::ST_DRAIN) |-> cell_valid[0])
      else $error("drain with empty chain");

   a_empty_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_out) |=> (cell_valid == '0))
      else $error("chain not empty after final beat");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !full) |=> (dropped_ff == $past(dropped_ff)))
      else $error("overflow flag changed without a full chain");

   a_no_insert_in_drain: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift |-> !ctrl.ins)
      else $error("insert during drain");

endmodule

### rtl/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// one place of the sorted list: compares against the broadcast value on
// insert, takes the lower neighbor's entry when it moves up, and takes the
// upper neighbor's entry when the list drains
// ----------------------------------------------------------------------------
module isort_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  isort_pkg::cell_ctrl_type              ctrl,
   input  logic signed [isort_pkg::DATA_WIDTH-1:0] ins_value,
   input  logic signed [isort_pkg::DATA_WIDTH-1:0] left_value,
   input  logic                                  left_valid,
   input  logic                                  left_gt,
   input  logic signed [isort_pkg::DATA_WIDTH-1:0] right_value,
   input  logic                                  right_valid,
   output logic signed [isort_pkg::DATA_WIDTH-1:0] value,
   output logic                                  valid,
   output logic                                  gt
);

   logic signed [isort_pkg::DATA_WIDTH-1:0] value_ff;
   logic signed [isort_pkg::DATA_WIDTH-1:0] value_in;
   logic                                    valid_ff;
   logic                                    valid_in;

   assign gt = valid_ff && (value_ff > ins_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.ins) begin
         if (gt || (!valid_ff && left_valid)) begin
            value_in = left_gt ? left_value : ins_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule
